>>> hdl/rtosm_pkg.sv
// Package for the radix count tree multiset: operation and status codes,
// default sizes. No dependencies.
package rtosm_pkg;

    localparam int KEY_BITS_DEF   = 12;
    localparam int DIGIT_BITS_DEF = 4;
    localparam int COUNT_BITS_DEF = 20;

    localparam int KEY_W    = 32;
    localparam int RANK_W   = 19;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD          = 4'd0,
        OP_REMOVE       = 4'd1,
        OP_ADD_ABSENT   = 4'd2,
        OP_REMOVE_PRES  = 4'd3,
        OP_REMOVE_ALL   = 4'd4,
        OP_COUNT        = 4'd5,
        OP_COUNT_LT     = 4'd6,
        OP_COUNT_LE     = 4'd7,
        OP_NTH          = 4'd8,
        OP_LOWER_BOUND  = 4'd9,
        OP_UPPER_BOUND  = 4'd10,
        OP_SIZE         = 4'd11
    } t_op;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANK  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

endpackage

>>> hdl/radix_trie_order_statistic_multiset.sv
// Top level of the radix count tree multiset: sequencer, shared adder and
// compare, and the tree memory (one read, one write port). Depends on rtosm_pkg.

// Keys are offset by key_base and kept in a count tree of DIGIT_BITS-bit
// digits; node totals and leaf counts share one memory with one access per
// cycle, and every count or walk step is a read through that port followed
// by one add/compare. After reset a clearing pass writes zero to every entry
// (node count plus 2^KEY_BITS entries, 4369 at the defaults) with busy high.
// A transaction is taken when start is high and busy is low. Out-of-range keys
// and unused codes go straight to done; the rest first read the leaf and root
// counts. An applied update reads and writes one entry on every level, the rank
// counts add lower siblings level by level, nth descends by child totals, and
// a bound query runs a rank count and then, if it is below the size, an nth walk.
// Each result is shown for one cycle with o_done high; it cannot be held off.
module radix_trie_order_statistic_multiset
    import rtosm_pkg::*;
#(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int DIGIT_BITS = DIGIT_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [KEY_W-1:0]             i_cfg_data,
    input  logic                         start,
    output logic                         busy,
    input  logic [OP_W-1:0]              i_operation,
    input  logic [KEY_W-1:0]             i_key,
    input  logic [RANK_W-1:0]            i_rank,
    output logic                         o_done,
    output logic signed [COUNT_BITS-1:0] o_count_out,
    output logic [KEY_W-1:0]             o_value_out,
    output logic                         o_value_found,
    output logic [STATUS_W-1:0]          o_status
);

    localparam int KB     = KEY_BITS;
    localparam int DB     = DIGIT_BITS;
    localparam int CB     = COUNT_BITS;
    localparam int LEVELS = (KB + DB - 1) / DB;
    localparam int FANOUT = 1 << DB;
    localparam int SW     = (CB + KB + 2 > RANK_W + 2) ? CB + KB + 2 : RANK_W + 2;
    localparam int WW     = KB + DB + 1;
    localparam int LW     = $clog2(LEVELS + 1);

    function automatic int lvl_size(int l);
        int sh;
        sh = DB * (LEVELS - l);
        if (sh >= KB) return 1;
        return 1 << (KB - sh);
    endfunction

    function automatic int lvl_off_c(int l);
        int off;
        off = 0;
        for (int i = 0; i < LEVELS + 1; i++) begin
            if (i < l) off += lvl_size(i);
        end
        return off;
    endfunction

    localparam int LEAF_OFF = lvl_off_c(LEVELS);
    localparam int DEPTH    = LEAF_OFF + (1 << KB);
    localparam int AW       = $clog2(DEPTH);

    localparam logic [KB-1:0] MASK_K = KB'((1 << DB) - 1);
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'd1 << (CB - 1)) - 64'd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    function automatic logic [AW-1:0] lvl_off(int l);
        return AW'(lvl_off_c(l));
    endfunction

    function automatic logic [KB-1:0] pfx(logic [KB-1:0] d, int l);
        int sh;
        sh = DB * (LEVELS - l);
        if (sh >= KB) return '0;
        return d >> sh;
    endfunction

    function automatic logic signed [CB-1:0] sat(logic signed [SW-1:0] v);
        if (v > SAT_HI) return CB'(SAT_HI);
        if (v < SAT_LO) return CB'(SAT_LO);
        return CB'(v);
    endfunction

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LEAF_RD, S_ROOT_RD, S_DISPATCH, S_UPD_RD, S_UPD_WR,
        S_CB_CHK, S_CB_ACC, S_CB_FIN, S_NTH_CHK, S_NTH_ACC, S_DONE
    } t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_clr;
    logic [KEY_W-1:0]        r_key_base;
    logic [OP_W-1:0]         r_op;
    logic [KB-1:0]           r_d;
    logic [RANK_W-1:0]       r_rank;
    logic signed [CB-1:0]    r_leaf;
    logic signed [CB-1:0]    r_size;
    logic signed [CB:0]      r_diff;
    logic [LW-1:0]           r_lvl;
    logic [DB:0]             r_j;
    logic [KB-1:0]           r_p;
    logic signed [SW-1:0]    r_sum;
    logic signed [SW-1:0]    r_n;
    logic signed [SW-1:0]    r_k;
    logic                    r_done;
    logic signed [CB-1:0]    r_cnt;
    logic [KEY_W-1:0]        r_val;
    logic                    r_fnd;
    logic [STATUS_W-1:0]     r_sts;

    logic signed [CB-1:0]    mem [0:DEPTH-1];
    logic signed [CB-1:0]    r_rdata;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [CB-1:0]    mem_wdata;
    logic [AW-1:0]           mem_raddr;

    logic [KEY_W-1:0]        key_off;
    logic                    uses_key;
    logic [AW-1:0]           upd_addr;
    logic [KB-1:0]           child_pfx;
    logic [WW-1:0]           cb_c;
    logic [WW-1:0]           j_w;
    logic [AW-1:0]           cb_addr;
    logic [WW-1:0]           ch_w;
    logic [WW-1:0]           size_w;
    logic [AW-1:0]           nth_addr;
    logic signed [SW-1:0]    rd_sx;
    logic signed [SW-1:0]    upd_sum;
    logic signed [SW-1:0]    cb_tot;
    logic signed [CB-1:0]    cb_cnt;
    logic signed [SW-1:0]    k_next;

    always_comb begin
        key_off   = i_key - r_key_base;
        uses_key  = (i_operation <= OP_COUNT_LE) || (i_operation == OP_LOWER_BOUND)
                    || (i_operation == OP_UPPER_BOUND);
        upd_addr  = lvl_off(int'(r_lvl)) + AW'(pfx(r_d, int'(r_lvl)));
        child_pfx = pfx(r_d, int'(r_lvl) + 1);
        cb_c      = WW'(child_pfx & MASK_K);
        j_w       = WW'(r_j);
        cb_addr   = lvl_off(int'(r_lvl) + 1)
                    + AW'((WW'(child_pfx) & ~WW'(MASK_K)) | j_w);
        ch_w      = (WW'(r_p) << DB) | j_w;
        size_w    = WW'(lvl_size(int'(r_lvl) + 1));
        nth_addr  = lvl_off(int'(r_lvl) + 1) + AW'(ch_w);
        rd_sx     = SW'(r_rdata);
        upd_sum   = rd_sx + SW'(r_diff);
        cb_tot    = r_sum + (((r_op == OP_COUNT_LE) || (r_op == OP_UPPER_BOUND))
                             ? SW'(r_leaf) : '0);
        cb_cnt    = sat(cb_tot);
        k_next    = r_k + rd_sx;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = upd_addr;
        mem_wdata = sat(upd_sum);
        mem_raddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_LEAF_RD: mem_raddr = AW'(LEAF_OFF) + AW'(r_d);
            S_UPD_RD:  mem_raddr = upd_addr;
            S_UPD_WR:  mem_we    = 1'b1;
            S_CB_CHK:  mem_raddr = cb_addr;
            S_NTH_CHK: mem_raddr = nth_addr;
            default:   mem_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_key_base <= '0;
            r_done     <= 1'b0;
        end else begin
            if (i_cfg_we) r_key_base <= i_cfg_data;
            r_done <= (r_state == S_DONE);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_op   <= i_operation;
                        r_d    <= KB'(key_off);
                        r_rank <= i_rank;
                        r_cnt  <= '0;
                        r_val  <= '0;
                        r_fnd  <= 1'b0;
                        if (uses_key && (key_off >> KB) != '0) begin
                            r_sts   <= STATUS_RANGE;
                            r_state <= S_DONE;
                        end else if (i_operation > OP_SIZE) begin
                            r_sts   <= STATUS_OK;
                            r_state <= S_DONE;
                        end else begin
                            r_sts   <= STATUS_OK;
                            r_state <= S_LEAF_RD;
                        end
                    end
                end
                S_LEAF_RD: r_state <= S_ROOT_RD;
                S_ROOT_RD: begin
                    r_leaf  <= (r_op == OP_NTH || r_op == OP_SIZE) ? '0 : r_rdata;
                    r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    r_size <= r_rdata;
                    r_lvl  <= '0;
                    r_j    <= '0;
                    r_p    <= '0;
                    r_k    <= '0;
                    r_sum  <= '0;
                    case (r_op) inside
                        OP_ADD: begin
                            r_diff  <= (CB+1)'(1);
                            r_state <= S_UPD_RD;
                        end
                        OP_REMOVE: begin
                            r_diff  <= -(CB+1)'(1);
                            r_state <= S_UPD_RD;
                        end
                        OP_ADD_ABSENT: begin
                            r_diff  <= (CB+1)'(1);
                            r_state <= (r_leaf == '0) ? S_UPD_RD : S_DONE;
                        end
                        OP_REMOVE_PRES: begin
                            r_diff  <= -(CB+1)'(1);
                            r_state <= (r_leaf > 0) ? S_UPD_RD : S_DONE;
                        end
                        OP_REMOVE_ALL: begin
                            r_diff  <= -((CB+1)'(r_leaf));
                            r_state <= (r_leaf > 0) ? S_UPD_RD : S_DONE;
                        end
                        OP_COUNT: begin
                            r_cnt   <= r_leaf;
                            r_state <= S_DONE;
                        end
                        OP_SIZE: begin
                            r_cnt   <= r_rdata;
                            r_state <= S_DONE;
                        end
                        OP_COUNT_LT, OP_COUNT_LE, OP_LOWER_BOUND, OP_UPPER_BOUND:
                            r_state <= S_CB_CHK;
                        OP_NTH: begin
                            r_n <= SW'(r_rank);
                            // a negative size means no rank can be found
                            if (signed'(SW'(r_rank)) >= rd_sx) begin
                                r_sts   <= STATUS_RANK;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_NTH_CHK;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_UPD_RD: r_state <= S_UPD_WR;
                S_UPD_WR: begin
                    if (r_lvl == LW'(LEVELS)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_lvl   <= r_lvl + LW'(1);
                        r_state <= S_UPD_RD;
                    end
                end
                S_CB_CHK: begin
                    if (j_w < cb_c) begin
                        r_state <= S_CB_ACC;
                    end else if (r_lvl == LW'(LEVELS - 1)) begin
                        r_state <= S_CB_FIN;
                    end else begin
                        r_lvl <= r_lvl + LW'(1);
                        r_j   <= '0;
                    end
                end
                S_CB_ACC: begin
                    r_sum   <= r_sum + rd_sx;
                    r_j     <= r_j + (DB+1)'(1);
                    r_state <= S_CB_CHK;
                end
                S_CB_FIN: begin
                    r_cnt <= cb_cnt;
                    r_lvl <= '0;
                    r_j   <= '0;
                    r_p   <= '0;
                    r_k   <= '0;
                    r_n   <= SW'(cb_cnt);
                    if ((r_op == OP_LOWER_BOUND || r_op == OP_UPPER_BOUND)
                        && cb_cnt >= 0 && cb_cnt < r_size)
                        r_state <= S_NTH_CHK;
                    else
                        r_state <= S_DONE;
                end
                S_NTH_CHK: begin
                    if (j_w == WW'(FANOUT) || ch_w >= size_w) begin
                        if (r_op == OP_NTH) r_sts <= STATUS_RANK;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_NTH_ACC;
                    end
                end
                S_NTH_ACC: begin
                    if (k_next > r_n) begin
                        if (r_lvl == LW'(LEVELS - 1)) begin
                            r_val   <= r_key_base + KEY_W'(KB'(ch_w));
                            r_fnd   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_p     <= KB'(ch_w);
                            r_n     <= r_n - r_k;
                            r_k     <= '0;
                            r_j     <= '0;
                            r_lvl   <= r_lvl + LW'(1);
                            r_state <= S_NTH_CHK;
                        end
                    end else begin
                        r_k     <= k_next;
                        r_j     <= r_j + (DB+1)'(1);
                        r_state <= S_NTH_CHK;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_count_out   = r_cnt;
    assign o_value_out   = r_val;
    assign o_value_found = r_fnd;
    assign o_status      = r_sts;

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DONE))
        else $error("result strobe without a finished transaction");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_value_found) |-> (o_status == STATUS_OK))
        else $error("key found with error status");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == STATUS_RANGE) |-> (o_count_out == '0 && o_value_out == '0))
        else $error("out-of-range result not zero");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("tree memory written while idle");

endmodule
